### rtl/jets_pkg.sv
package jets_pkg;

    localparam int DATA_W = 32;
    localparam int ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_ORIGIN_REAL = 3'd0,
        REG_ORIGIN_IMAG = 3'd1,
        REG_STEP_REAL   = 3'd2,
        REG_STEP_IMAG   = 3'd3,
        REG_CONST_REAL  = 3'd4,
        REG_CONST_IMAG  = 3'd5,
        REG_ITER_LIMIT  = 3'd6,
        REG_ESC_LIMIT   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] origin_real;
        logic signed [31:0] origin_imag;
        logic [30:0]        step_real;
        logic [30:0]        step_imag;
        logic signed [31:0] const_real;
        logic signed [31:0] const_imag;
        logic [7:0]         iteration_limit;
        logic [30:0]        escape_limit;
    } cfg_t;

endpackage

### rtl/jets_cfg.sv
module jets_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [jets_pkg::ADDR_W-1:0]  paddr,
    input  logic [jets_pkg::DATA_W-1:0]  pwdata,
    output logic [jets_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output jets_pkg::cfg_t               cfg
);
    import jets_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_real     <= -32'sd402653184;
            cfg_reg.origin_imag     <= -32'sd402653184;
            cfg_reg.step_real       <= 31'd1007895;
            cfg_reg.step_imag       <= 31'd1007895;
            cfg_reg.const_real      <= 32'sd134217728;
            cfg_reg.const_imag      <= 32'sd134217728;
            cfg_reg.iteration_limit <= 8'd100;
            cfg_reg.escape_limit    <= 31'd536870912;
        end else if (wr_en) begin
            unique case (idx)
                REG_ORIGIN_REAL: cfg_reg.origin_real     <= $signed(pwdata);
                REG_ORIGIN_IMAG: cfg_reg.origin_imag     <= $signed(pwdata);
                REG_STEP_REAL:   cfg_reg.step_real       <= pwdata[30:0];
                REG_STEP_IMAG:   cfg_reg.step_imag       <= pwdata[30:0];
                REG_CONST_REAL:  cfg_reg.const_real      <= $signed(pwdata);
                REG_CONST_IMAG:  cfg_reg.const_imag      <= $signed(pwdata);
                REG_ITER_LIMIT:  cfg_reg.iteration_limit <= pwdata[7:0];
                REG_ESC_LIMIT:   cfg_reg.escape_limit    <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_ORIGIN_REAL: prdata = cfg_reg.origin_real;
            REG_ORIGIN_IMAG: prdata = cfg_reg.origin_imag;
            REG_STEP_REAL:   prdata = {1'b0, cfg_reg.step_real};
            REG_STEP_IMAG:   prdata = {1'b0, cfg_reg.step_imag};
            REG_CONST_REAL:  prdata = cfg_reg.const_real;
            REG_CONST_IMAG:  prdata = cfg_reg.const_imag;
            REG_ITER_LIMIT:  prdata = {24'd0, cfg_reg.iteration_limit};
            REG_ESC_LIMIT:   prdata = {1'b0, cfg_reg.escape_limit};
            default:         prdata = '0;
        endcase
    end

endmodule

### rtl/jets_mul.sv
module jets_mul (
    input  logic                aclk,
    input  logic signed [32:0]  a,
    input  logic signed [32:0]  b,
    output logic signed [65:0]  p
);
    import jets_pkg::*;

    logic signed [65:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

### rtl/julia_escape_time_pixel_unit.sv
// Sequence per word: S_STR, S_STI, then S_SQR, S_SQI, S_CRS, S_TST per iteration, S_OUT.
// A new word is taken only in S_IDLE; one shared 33x33 multiplier does the
// start point and three products (re*re, im*im, re*im) per iteration.
// Reset: synchronous active-low aresetn returns the sequencer to idle, drops m_tvalid
// and loads the configuration registers with their defaults.
module julia_escape_time_pixel_unit #(
    parameter int MAX_DIM   = 1024,
    parameter int FRAC_BITS = 28
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [jets_pkg::ADDR_W-1:0]  paddr,
    input  logic [jets_pkg::DATA_W-1:0]  pwdata,
    output logic [jets_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [23:0]                  s_tdata,  // column, row, zero pad
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // out_column, out_row, escape_count, red, green, blue, zero pad
    output logic [55:0]                  m_tdata,
    output logic                         m_tuser   // escaped
);
    import jets_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_STR  = 8'b0000_0010,
        S_STI  = 8'b0000_0100,
        S_SQR  = 8'b0000_1000,
        S_SQI  = 8'b0001_0000,
        S_CRS  = 8'b0010_0000,
        S_TST  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX)      r = 32'sh7FFF_FFFF;
        else if (v < SAT_MIN) r = 32'sh8000_0000;
        else                  r = v[31:0];
        return r;
    endfunction

    function automatic logic [9:0] clamp_idx(input logic [9:0] idx);
        logic [9:0] r;
        if ({22'd0, idx} >= 32'(MAX_DIM)) r = 10'(MAX_DIM - 1);
        else                              r = idx;
        return r;
    endfunction

    cfg_t cfg;

    state_t state_reg, state_next;
    logic [9:0]         col_reg, row_reg;
    logic signed [31:0] re_reg, re_next, im_reg, im_next;
    logic signed [63:0] rr_reg, ii_reg;
    logic [7:0]         cnt_reg, cnt_next;
    logic               esc_reg, esc_next;
    logic               m_valid_reg;
    logic [55:0]        m_data_reg;
    logic               m_user_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [63:0]        mod_sq, bound;
    logic signed [63:0] diff, diff_sh, cross_sh;
    logic [7:0]         entry;
    logic               out_free;

    jets_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    jets_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    always_comb begin
        unique case (state_reg)
            S_STR: begin
                mul_a = $signed({23'd0, clamp_idx(col_reg)});
                mul_b = $signed({2'b00, cfg.step_real});
            end
            S_STI: begin
                mul_a = $signed({23'd0, clamp_idx(row_reg)});
                mul_b = $signed({2'b00, cfg.step_imag});
            end
            S_SQR: begin
                mul_a = {re_reg[31], re_reg};
                mul_b = {re_reg[31], re_reg};
            end
            S_SQI: begin
                mul_a = {im_reg[31], im_reg};
                mul_b = {im_reg[31], im_reg};
            end
            S_CRS: begin
                mul_a = {re_reg[31], re_reg};
                mul_b = {im_reg[31], im_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mod_sq   = {1'b0, rr_reg[62:0]} + {1'b0, ii_reg[62:0]};
    assign bound    = 64'(cfg.escape_limit) << FRAC_BITS;
    assign diff     = rr_reg - ii_reg;
    assign diff_sh  = diff >>> FRAC_BITS;
    assign cross_sh = $signed(mul_p[63:0]) >>> (FRAC_BITS - 1);
    assign out_free = !m_valid_reg || m_tready;
    assign entry    = esc_reg ? cnt_reg : 8'd0;

    always_comb begin
        state_next = state_reg;
        re_next    = re_reg;
        im_next    = im_reg;
        cnt_next   = cnt_reg;
        esc_next   = esc_reg;
        unique case (state_reg)
            S_IDLE: if (s_tvalid) state_next = S_STR;
            S_STR:  state_next = S_STI;
            S_STI: begin
                re_next    = sat32(mul_p + {{34{cfg.origin_real[31]}}, cfg.origin_real});
                cnt_next   = 8'd0;
                state_next = S_SQR;
            end
            S_SQR: begin
                if (cnt_reg == 8'd0)
                    im_next = sat32(mul_p + {{34{cfg.origin_imag[31]}}, cfg.origin_imag});
                state_next = S_SQI;
            end
            S_SQI:  state_next = S_CRS;
            S_CRS:  state_next = S_TST;
            S_TST: begin
                if (mod_sq > bound) begin
                    esc_next   = 1'b1;
                    state_next = S_OUT;
                end else if (cnt_reg >= cfg.iteration_limit) begin
                    esc_next   = 1'b0;
                    state_next = S_OUT;
                end else begin
                    re_next    = sat32({{2{diff_sh[63]}}, diff_sh}
                                       + {{34{cfg.const_real[31]}}, cfg.const_real});
                    im_next    = sat32({{2{cross_sh[63]}}, cross_sh}
                                       + {{34{cfg.const_imag[31]}}, cfg.const_imag});
                    cnt_next   = cnt_reg + 8'd1;
                    state_next = S_SQR;
                end
            end
            S_OUT:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            esc_reg     <= 1'b0;
            cnt_reg     <= 8'd0;
        end else begin
            state_reg <= state_next;
            esc_reg   <= (state_reg == S_STI) ? 1'b0 : esc_next;
            cnt_reg   <= cnt_next;
            if (state_reg == S_OUT && out_free)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        re_reg <= re_next;
        im_reg <= im_next;
        if (state_reg == S_IDLE && s_tvalid) begin
            col_reg <= s_tdata[9:0];
            row_reg <= s_tdata[19:10];
        end
        if (state_reg == S_SQI) rr_reg <= mul_p[63:0];
        if (state_reg == S_CRS) ii_reg <= mul_p[63:0];
        if (state_reg == S_OUT && out_free) begin
            m_data_reg <= {4'd0,
                           8'(entry * 8'd5),
                           8'((entry + 8'd1) * 8'd5),
                           8'((entry + 8'd2) * 8'd5),
                           cnt_reg, row_reg, col_reg};
            m_user_reg <= esc_reg;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
